FILE: rtl/kmp_first_match_finder_assert.svh
// assertion macros shared by the string match block
`ifndef KMP_FIRST_MATCH_FINDER_ASSERT_SVH
`define KMP_FIRST_MATCH_FINDER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define KMP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define KMP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/kmp_pkg.sv
// types and constants of the first-match string search block
package kmp_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_PATTERN_LOW    = 2'd0;
	localparam logic [1:0] REG_PATTERN_HIGH   = 2'd1;
	localparam logic [1:0] REG_PATTERN_LENGTH = 2'd2;

	localparam int CFG_INDEX_W   = 2;
	localparam int CFG_DATA_W    = 64;
	localparam int LENGTH_W      = 5;
	localparam int BYTES_PER_REG = 8;
	localparam int PATTERN_BYTES = 16;
	localparam int RESULT_OFFSET_W = 32;

	// text byte transaction
	typedef struct packed {
		logic [7:0] text_byte;
		logic       last_byte;
	} kmp_text_t;

	// result transaction
	typedef struct packed {
		logic                       found;
		logic [RESULT_OFFSET_W-1:0] start_offset;
	} kmp_result_t;

	// control shared by every cell of the row
	typedef struct packed {
		logic advance;
		logic clear;
	} kmp_cell_ctrl_t;

endpackage

FILE: rtl/kmp_stream_if.sv
// valid/ready stream channel carrying one payload
interface kmp_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/kmp_cell.sv
// one matcher cell: tracks whether the pattern prefix ending at this byte matches
module kmp_cell
	import kmp_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  kmp_cell_ctrl_t ctrl,
	input  logic           prev_hit,
	input  logic [7:0]     pattern_byte,
	input  logic [7:0]     text_byte,
	output logic           hit_next,
	output logic           hit_q
);

	// prefix through this byte matches if the shorter prefix matched last byte
	assign hit_next = prev_hit & (text_byte == pattern_byte);

	// hit flag, handed to the next cell on the following byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctrl.clear) begin
			hit_q <= 1'b0;
		end else if (ctrl.advance) begin
			hit_q <= hit_next;
		end
	end

endmodule

FILE: rtl/kmp_first_match_finder.sv
// first-match string search over a byte stream, top level
// Takes one text byte per cycle and reports the first place a pattern of
// 1 to MAX_PATTERN bytes occurs. A row of MAX_PATTERN cells, one per pattern
// byte, moves the partial match one cell down on every accepted byte, so a
// match is known in the cycle its last byte is taken and the result sits in
// the output register from the next cycle on. Sustained rate is one byte per
// cycle; input stalls only while a result waits in the output register and
// the sink is not ready. A write to any pattern register restarts the search.
module kmp_first_match_finder
	import kmp_pkg::*;
#(
	parameter int MAX_PATTERN  = 16,
	parameter int OFFSET_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	kmp_stream_if.sink             text,
	kmp_stream_if.source           result,
	input  logic                   write_en,
	input  logic [CFG_INDEX_W-1:0] write_index,
	input  logic [CFG_DATA_W-1:0]  write_data
);

	localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	logic [CFG_DATA_W-1:0]   pattern_low_q;
	logic [CFG_DATA_W-1:0]   pattern_high_q;
	logic [IDX_W-1:0]        used_m1_q;
	logic [OFFSET_WIDTH-1:0] offset_q;
	logic                    found_q;
	logic                    out_valid_q;
	kmp_result_t             out_q;

	kmp_text_t               in_item;
	logic                    in_fire;
	logic                    cfg_hit;
	logic                    match;
	logic                    load;
	kmp_cell_ctrl_t          ctrl;
	logic [MAX_PATTERN-1:0]  hit_next;
	logic [MAX_PATTERN-1:0]  hit_q;
	logic [LENGTH_W-1:0]     length_wr;
	logic [IDX_W-1:0]        used_m1_wr;
	logic [OFFSET_WIDTH:0]   start_diff;
	logic [OFFSET_WIDTH-1:0] start_off;
	logic [OFFSET_WIDTH+RESULT_OFFSET_W-1:0] start_ext;

	assign in_item    = text.payload;
	assign text.ready = !out_valid_q || result.ready;
	assign in_fire    = text.valid && text.ready;

	// only writes to an existing register restart the search
	assign cfg_hit = write_en && (write_index == REG_PATTERN_LOW
		|| write_index == REG_PATTERN_HIGH || write_index == REG_PATTERN_LENGTH);

	// configuration registers; length kept as clamped last index
	assign length_wr = write_data[LENGTH_W-1:0];
	always_comb begin
		if (length_wr == '0) begin
			used_m1_wr = '0;
		end else if (int'(length_wr) > MAX_PATTERN) begin
			used_m1_wr = IDX_W'(MAX_PATTERN - 1);
		end else begin
			used_m1_wr = IDX_W'(length_wr - LENGTH_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q  <= '0;
			pattern_high_q <= '0;
			used_m1_q      <= '0;
		end else if (write_en) begin
			case (write_index)
				REG_PATTERN_LOW: begin
					pattern_low_q <= write_data;
				end
				REG_PATTERN_HIGH: begin
					pattern_high_q <= write_data;
				end
				REG_PATTERN_LENGTH: begin
					used_m1_q <= used_m1_wr;
				end
				default: begin
				end
			endcase
		end
	end

	// row of matcher cells
	assign match = hit_next[used_m1_q];
	assign ctrl.advance = in_fire && !found_q;
	assign ctrl.clear   = cfg_hit || (in_fire && (in_item.last_byte || match));

	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
		logic [7:0] pat_byte;
		logic       prev_hit;

		if (i < BYTES_PER_REG) begin : g_low
			assign pat_byte = pattern_low_q[BYTES_PER_REG*i +: BYTES_PER_REG];
		end else if (i < PATTERN_BYTES) begin : g_high
			assign pat_byte =
				pattern_high_q[BYTES_PER_REG*(i-BYTES_PER_REG) +: BYTES_PER_REG];
		end else begin : g_zero
			assign pat_byte = 8'h00;
		end

		if (i == 0) begin : g_head
			assign prev_hit = !found_q;
		end else begin : g_link
			assign prev_hit = hit_q[i-1];
		end

		kmp_cell u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctrl         (ctrl),
			.prev_hit     (prev_hit),
			.pattern_byte (pat_byte),
			.text_byte    (in_item.text_byte),
			.hit_next     (hit_next[i]),
			.hit_q        (hit_q[i])
		);
	end

	// match start = current offset minus pattern length plus one, floored at zero
	assign start_diff = {1'b0, offset_q} - {1'b0, OFFSET_WIDTH'(used_m1_q)};
	assign start_off  = start_diff[OFFSET_WIDTH] ? '0 : start_diff[OFFSET_WIDTH-1:0];
	assign start_ext  = {{RESULT_OFFSET_W{1'b0}}, start_off};

	// byte offset and found flag of the current text
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			found_q  <= 1'b0;
		end else if (cfg_hit || (in_fire && in_item.last_byte)) begin
			offset_q <= '0;
			found_q  <= 1'b0;
		end else if (in_fire) begin
			if (offset_q != '1) begin
				offset_q <= offset_q + OFFSET_WIDTH'(1);
			end
			if (!found_q && match) begin
				found_q <= 1'b1;
			end
		end
	end

	// output register
	assign load = in_fire && !found_q && (match || in_item.last_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.found        <= match;
			out_q.start_offset <= match ? start_ext[RESULT_OFFSET_W-1:0] : '0;
		end
	end

	assign result.valid   = out_valid_q;
	assign result.payload = out_q;

	`include "kmp_first_match_finder_assert.svh"

	`KMP_ASSERT_NEXT(a_found_sticks, in_fire && match && !in_item.last_byte && !write_en,
		found_q, "match not recorded as found")
	`KMP_ASSERT_NOW(a_miss_zero, out_valid_q && !out_q.found,
		out_q.start_offset == '0, "not-found result with nonzero offset")
	`KMP_ASSERT_NEXT(a_cfg_clears, cfg_hit,
		hit_q == '0 && !found_q && offset_q == '0, "search not restarted by write")
	`KMP_ASSERT_NOW(a_stall_blocks, out_valid_q && !result.ready,
		!text.ready, "input taken while result stalled")
	`KMP_ASSERT_NEXT(a_offset_moves, in_fire && !in_item.last_byte && !write_en,
		offset_q != '0, "offset did not advance")

endmodule

FILE: bench/kmp_match_checker.sv
`timescale 1ns / 100ps
// scoreboard that predicts and checks the first-match search results
module kmp_match_checker
	import kmp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   text_valid,
	input  logic                   text_ready,
	input  kmp_text_t              text_payload,
	input  logic                   result_valid,
	input  logic                   result_ready,
	input  kmp_result_t            result_payload,
	input  logic                   write_en,
	input  logic [CFG_INDEX_W-1:0] write_index,
	input  logic [CFG_DATA_W-1:0]  write_data,
	output int                     outstanding,
	output int                     errors
);

	// byte counter stops here (offset width equals the result field width)
	localparam logic [RESULT_OFFSET_W-1:0] OFFSET_CEIL = '1;

	// pattern registers as the block sees them
	logic [CFG_DATA_W-1:0]      pat_lo;
	logic [CFG_DATA_W-1:0]      pat_hi;
	logic [LENGTH_W-1:0]        pat_len;

	// search state
	logic [LENGTH_W-1:0]        prefix_len [PATTERN_BYTES];
	logic [LENGTH_W-1:0]        matched;
	logic [RESULT_OFFSET_W-1:0] text_pos;
	logic                       reported;

	// results still owed by the block, oldest first
	kmp_result_t                owed_q [$];

	function automatic logic [7:0] pattern_byte(input int idx);
		if (idx < BYTES_PER_REG)
			return pat_lo[8*idx +: 8];
		return pat_hi[8*(idx-BYTES_PER_REG) +: 8];
	endfunction

	// length in use: zero acts as one, anything past the table acts as full
	function automatic int pattern_span();
		if (pat_len == '0)
			return 1;
		if (pat_len > PATTERN_BYTES)
			return PATTERN_BYTES;
		return int'(pat_len);
	endfunction

	// longest proper prefix that is also a suffix, per pattern position
	function automatic void rebuild_prefix();
		int n;
		int k;
		int q;
		n = pattern_span();
		k = 0;
		for (q = 0; q < PATTERN_BYTES; q++)
			prefix_len[q] = '0;
		for (q = 1; q < n; q++) begin
			while (k > 0 && pattern_byte(k) != pattern_byte(q))
				k = int'(prefix_len[k-1]);
			if (pattern_byte(k) == pattern_byte(q))
				k++;
			prefix_len[q] = LENGTH_W'(k);
		end
	endfunction

	function automatic void restart_search();
		matched  = '0;
		text_pos = '0;
		reported = 1'b0;
	endfunction

	// advance the search by one text byte and queue what it produces
	function automatic void take_byte(input logic [7:0] b, input logic last);
		int                         n;
		int                         q;
		logic [RESULT_OFFSET_W-1:0] here;
		logic                       hit;
		kmp_result_t                res;
		n    = pattern_span();
		here = text_pos;
		hit  = 1'b0;
		if (text_pos != OFFSET_CEIL)
			text_pos = text_pos + 1'b1;
		if (!reported) begin
			q = int'(matched);
			if (q >= n)
				q = 0;
			while (q > 0 && pattern_byte(q) != b)
				q = int'(prefix_len[q-1]);
			if (pattern_byte(q) == b)
				q++;
			if (q == n) begin
				res.found        = 1'b1;
				res.start_offset = (here >= n - 1) ? here - (n - 1) : '0;
				owed_q.push_back(res);
				hit      = 1'b1;
				reported = 1'b1;
				q        = 0;
			end
			matched = LENGTH_W'(q);
			// text ended with no match
			if (last && !hit) begin
				res.found        = 1'b0;
				res.start_offset = '0;
				owed_q.push_back(res);
			end
		end
		if (last)
			restart_search();
	endfunction

	// watch every channel once per clock
	always @(posedge clk or negedge arst_n) begin : watch
		int          fails;
		kmp_result_t want;
		if (!arst_n) begin
			pat_lo  = '0;
			pat_hi  = '0;
			pat_len = LENGTH_W'(1);
			rebuild_prefix();
			restart_search();
			owed_q.delete();
			errors      <= 0;
			outstanding <= 0;
		end else begin
			fails = 0;
			// compare a result transaction with the oldest prediction
			if (result_valid && result_ready) begin
				if (owed_q.size() == 0) begin
					$display("%0t: unexpected result: found %0b start_offset %0d",
						$time, result_payload.found, result_payload.start_offset);
					fails++;
				end else begin
					want = owed_q.pop_front();
					if (result_payload.found !== want.found) begin
						$display("%0t: found mismatch: expected %0b actual %0b",
							$time, want.found, result_payload.found);
						fails++;
					end
					if (result_payload.start_offset !== want.start_offset) begin
						$display("%0t: start_offset mismatch: expected %0d actual %0d",
							$time, want.start_offset, result_payload.start_offset);
						fails++;
					end
				end
			end
			// writes to a pattern register rebuild the table and restart the search
			if (write_en) begin
				case (write_index)
					REG_PATTERN_LOW: begin
						pat_lo = write_data;
						rebuild_prefix();
						restart_search();
					end
					REG_PATTERN_HIGH: begin
						pat_hi = write_data;
						rebuild_prefix();
						restart_search();
					end
					REG_PATTERN_LENGTH: begin
						pat_len = write_data[LENGTH_W-1:0];
						rebuild_prefix();
						restart_search();
					end
					default: ;
				endcase
			end
			// text transaction
			if (text_valid && text_ready)
				take_byte(text_payload.text_byte, text_payload.last_byte);
			errors      <= errors + fails;
			outstanding <= owed_q.size();
		end
	end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// stimulus and verdict for the first-match string search block
module tb;
	import kmp_pkg::*;

	// index past the register list, writes to it change nothing
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;
	localparam int HOLD_CYCLES       = 300;
	localparam int STALL_LIMIT       = 2000;
	localparam int SETTLE_CYCLES     = 4;
	localparam int BYTES_PER_SETTING = 87;
	localparam int PRESSURE_TEXTS    = 60;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   write_en;
	logic [CFG_INDEX_W-1:0] write_index;
	logic [CFG_DATA_W-1:0]  write_data;

	int outstanding;
	int errors;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_ask = 0;
	int quiet_cycles = 0;
	int bytes_sent = 0;

	// local copy of the pattern for building texts
	logic [7:0] pat [PATTERN_BYTES];
	int         pat_n = 1;
	logic [7:0] alphabet [3];

	kmp_stream_if #(.payload_t(kmp_text_t))   text_ch ();
	kmp_stream_if #(.payload_t(kmp_result_t)) result_ch ();

	kmp_first_match_finder dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.text        (text_ch.sink),
		.result      (result_ch.source),
		.write_en    (write_en),
		.write_index (write_index),
		.write_data  (write_data)
	);

	kmp_match_checker match_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.text_valid     (text_ch.valid),
		.text_ready     (text_ch.ready),
		.text_payload   (text_ch.payload),
		.result_valid   (result_ch.valid),
		.result_ready   (result_ch.ready),
		.result_payload (result_ch.payload),
		.write_en       (write_en),
		.write_index    (write_index),
		.write_data     (write_data),
		.outstanding    (outstanding),
		.errors         (errors)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result sink: random stalls, plus a long hold-off on request
	initial begin : sink
		int hold_seen;
		hold_seen = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_ask != hold_seen) begin
				hold_seen = hold_ask;
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// watchdog on cycles with no transaction at all
	always @(posedge clk) begin
		if ((text_ch.valid && text_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// offer one text byte, with random gaps, until it is taken
	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			text_ch.valid <= 1'b0;
			@(posedge clk);
		end
		text_ch.valid   <= 1'b1;
		text_ch.payload <= kmp_text_t'{text_byte: b, last_byte: last};
		@(posedge clk);
		while (!text_ch.ready)
			@(posedge clk);
		bytes_sent++;
	endtask

	// stop offering, wait for every owed result, then let the block settle
	task automatic quiesce();
		text_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write enable stays high, the caller lowers it after the last write
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		write_en    <= 1'b1;
		write_index <= idx;
		write_data  <= val;
		@(posedge clk);
	endtask

	task automatic configure(input logic [CFG_DATA_W-1:0] lo, input logic [CFG_DATA_W-1:0] hi,
		input logic [CFG_DATA_W-1:0] len_word);
		int i;
		write_reg(REG_PATTERN_LOW, lo);
		write_reg(REG_PATTERN_HIGH, hi);
		write_reg(REG_PATTERN_LENGTH, len_word);
		write_en <= 1'b0;
		@(posedge clk);
		for (i = 0; i < BYTES_PER_REG; i++) begin
			pat[i]               = lo[8*i +: 8];
			pat[i+BYTES_PER_REG] = hi[8*i +: 8];
		end
		if (len_word[LENGTH_W-1:0] == '0)
			pat_n = 1;
		else if (len_word[LENGTH_W-1:0] > PATTERN_BYTES)
			pat_n = PATTERN_BYTES;
		else
			pat_n = int'(len_word[LENGTH_W-1:0]);
	endtask

	// one text: mostly pattern-alphabet bytes, often with the pattern planted
	task automatic send_random_text();
		int         tlen;
		int         at;
		int         i;
		bit         plant;
		bit         noise;
		logic [7:0] b;
		tlen  = $urandom_range(1, pat_n + 12);
		plant = ($urandom_range(1) == 1) && (tlen >= pat_n);
		at    = plant ? $urandom_range(0, tlen - pat_n) : tlen;
		noise = ($urandom_range(9) == 0);
		for (i = 0; i < tlen; i++) begin
			if (plant && i >= at && i < at + pat_n)
				b = pat[i-at];
			else if (noise || $urandom_range(9) == 0)
				b = 8'($urandom_range(255));
			else
				b = alphabet[$urandom_range(2)];
			send_byte(b, i == tlen - 1);
		end
	endtask

	initial begin : stimulus
		int                    ph;
		int                    s;
		int                    i;
		int                    mark;
		logic [CFG_DATA_W-1:0] lo;
		logic [CFG_DATA_W-1:0] hi;
		logic [CFG_DATA_W-1:0] len_word;
		logic [LENGTH_W-1:0]   len_code;

		arst_n = 1'b0;
		text_ch.valid   <= 1'b0;
		text_ch.payload <= '0;
		write_en        <= 1'b0;
		write_index     <= '0;
		write_data      <= '0;
		for (i = 0; i < PATTERN_BYTES; i++)
			pat[i] = 8'h00;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset pattern: single zero byte
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'hFF, 1'b1);

		// length zero acts as one, match on the last byte
		quiesce();
		configure('1, '0, '0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'hFF, 1'b1);

		// "aab": fallback after a partial match, then a miss
		quiesce();
		configure(64'h0000_0000_0062_6161, '0, 64'd3);
		send_byte(8'h61, 1'b0);
		send_byte(8'h61, 1'b0);
		send_byte(8'h61, 1'b0);
		send_byte(8'h62, 1'b1);
		send_byte(8'h61, 1'b0);
		send_byte(8'h62, 1'b1);

		// writes in the middle of a text restart the search
		send_byte(8'h61, 1'b0);
		send_byte(8'h61, 1'b0);
		quiesce();
		configure(64'h0000_0000_0062_6161, '1, 64'd2);
		send_byte(8'h62, 1'b0);
		send_byte(8'h61, 1'b0);
		// a write past the register list keeps the progress
		quiesce();
		write_reg(REG_SPARE, '1);
		write_en <= 1'b0;
		@(posedge clk);
		send_byte(8'h61, 1'b1);

		// length above the table acts as full length
		quiesce();
		configure('0, 64'hFF00_0000_0000_0000, 64'd31);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b1);

		// random texts over several pattern settings in each idle mix
		for (ph = 0; ph < 3; ph++) begin
			quiesce();
			send_idle_pct <= (ph == 0) ? 14 : (ph == 1) ? 86 : 0;
			recv_idle_pct <= (ph == 0) ? 86 : (ph == 1) ? 14 : 0;
			for (s = 0; s < 6; s++) begin
				quiesce();
				alphabet[0] = 8'($urandom_range(255));
				alphabet[1] = ~alphabet[0];
				alphabet[2] = 8'($urandom_range(255));
				for (i = 0; i < BYTES_PER_REG; i++) begin
					lo[8*i +: 8] = ($urandom_range(7) == 0) ? 8'($urandom_range(255))
						: alphabet[$urandom_range(1)];
					hi[8*i +: 8] = ($urandom_range(7) == 0) ? 8'($urandom_range(255))
						: alphabet[$urandom_range(1)];
				end
				case (s)
					0:       len_code = 5'd16;
					1:       len_code = 5'd1;
					2:       len_code = 5'($urandom_range(17, 31));
					3:       len_code = 5'd0;
					4:       len_code = 5'($urandom_range(2, 6));
					default: len_code = 5'($urandom_range(1, 16));
				endcase
				// upper data bits are ignored by the length register
				len_word = ($urandom_range(3) == 0) ? {$urandom, $urandom} : '0;
				len_word[LENGTH_W-1:0] = len_code;
				configure(lo, hi, len_word);
				mark = bytes_sent;
				while (bytes_sent - mark < BYTES_PER_SETTING)
					send_random_text();
			end
		end

		// long sink hold-off while single-byte texts keep coming
		quiesce();
		configure({56'h0, alphabet[0]}, '0, 64'd1);
		hold_ask <= hold_ask + 1;
		for (i = 0; i < PRESSURE_TEXTS; i++)
			send_byte(($urandom_range(1) == 1) ? alphabet[0] : alphabet[2], 1'b1);

		quiesce();
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

FILE: kmp_first_match_finder.f
+incdir+rtl
rtl/kmp_pkg.sv
rtl/kmp_stream_if.sv
rtl/kmp_cell.sv
rtl/kmp_first_match_finder.sv
bench/kmp_match_checker.sv
bench/tb.sv
